// ===== rtl/tlay_pkg.sv =====
// ----------------------------------------------------------------------------
// tlay_pkg
// Types, constants and helpers shared by the tiling layout block.
// ----------------------------------------------------------------------------
package tlay_pkg;

	localparam int MAX_VIEWS   = 32;
	localparam int CNT_W       = 6;
	localparam int IDX_W       = 5;
	localparam int DIM_W       = 16;
	localparam int RATIO_W     = 16;
	localparam int PAD_W       = 12;
	localparam int ROT_W       = 2;
	localparam int TAG_W       = 32;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 3;
	localparam int POS_W       = 19;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MAIN_COUNT    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAIN_RATIO    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_VIEW_PADDING  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTER_PADDING = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_ROTATION      = 3'd4;

	localparam logic [ROT_W-1:0] ROT_LEFT   = 2'd0;
	localparam logic [ROT_W-1:0] ROT_RIGHT  = 2'd1;
	localparam logic [ROT_W-1:0] ROT_TOP    = 2'd2;
	localparam logic [ROT_W-1:0] ROT_BOTTOM = 2'd3;

	localparam logic [CNT_W-1:0]   RST_MAIN_COUNT = 6'd1;
	localparam logic [RATIO_W-1:0] RST_MAIN_RATIO = 16'd39322;

	typedef struct packed {
		logic [CNT_W-1:0]   main_slots;
		logic [RATIO_W-1:0] main_ratio;
		logic [PAD_W-1:0]   inner_gap;
		logic [PAD_W-1:0]   edge_gap;
		logic [ROT_W-1:0]   rotation;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] num_views;
		logic [DIM_W-1:0] area_width;
		logic [DIM_W-1:0] area_height;
		logic [TAG_W-1:0] request_tag;
	} request_t;

	typedef struct packed {
		logic [IDX_W-1:0] view_index;
		logic [DIM_W-1:0] rect_x;
		logic [DIM_W-1:0] rect_y;
		logic [DIM_W-1:0] rect_width;
		logic [DIM_W-1:0] rect_height;
		logic [TAG_W-1:0] echo_tag;
		logic             last_rect;
	} result_t;

	typedef struct packed {
		logic [CNT_W-1:0] n;
		logic [CNT_W-1:0] mc;
		logic [DIM_W-1:0] ua;
		logic [DIM_W-1:0] mw;
		logic [DIM_W-1:0] sw;
		logic [DIM_W-1:0] mh;
		logic [IDX_W-1:0] mr;
		logic [DIM_W-1:0] sh;
		logic [IDX_W-1:0] sr;
		logic [TAG_W-1:0] tag;
	} job_t;

	typedef struct packed {
		logic             go;
		logic [DIM_W-1:0] num;
		logic [CNT_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [DIM_W-1:0] quo;
		logic [CNT_W-1:0] rem;
	} div_rsp_t;

	function automatic logic is_transposed(input logic [ROT_W-1:0] rot);
		logic t;
		case (rot)
			ROT_TOP, ROT_BOTTOM: t = 1'b1;
			default:             t = 1'b0;
		endcase
		return t;
	endfunction

	function automatic logic is_mirrored(input logic [ROT_W-1:0] rot);
		logic m;
		case (rot)
			ROT_RIGHT, ROT_BOTTOM: m = 1'b1;
			default:               m = 1'b0;
		endcase
		return m;
	endfunction

	function automatic logic [DIM_W-1:0] clamp16(input logic signed [POS_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v < 0)
			r = '0;
		else if (v > $signed({{(POS_W-DIM_W){1'b0}}, {DIM_W{1'b1}}}))
			r = {DIM_W{1'b1}};
		else
			r = v[DIM_W-1:0];
		return r;
	endfunction

endpackage

// ===== rtl/tlay_div.sv =====
// ----------------------------------------------------------------------------
// tlay_div
// Restoring divider, one quotient bit per cycle, for pixel extents by counts.
// ----------------------------------------------------------------------------
module tlay_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tlay_pkg::div_req_t req,
	output tlay_pkg::div_rsp_t rsp
);

	localparam int STEP_W = $clog2(tlay_pkg::DIM_W);

	logic                       run_q;
	logic                       done_q;
	logic [STEP_W-1:0]          step_q;
	logic [tlay_pkg::DIM_W-1:0] quo_q;
	logic [tlay_pkg::CNT_W-1:0] rem_q;
	logic [tlay_pkg::CNT_W-1:0] den_q;
	logic [tlay_pkg::CNT_W:0]   shifted;
	logic                       fits;

	assign shifted = {rem_q, quo_q[tlay_pkg::DIM_W-1]};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.go) begin
				run_q  <= 1'b1;
				step_q <= '0;
				quo_q  <= req.num;
				rem_q  <= '0;
				den_q  <= req.den;
			end else if (run_q) begin
				quo_q  <= {quo_q[tlay_pkg::DIM_W-2:0], fits};
				rem_q  <= fits ? tlay_pkg::CNT_W'(shifted - {1'b0, den_q})
				              : shifted[tlay_pkg::CNT_W-1:0];
				step_q <= step_q + 1'b1;
				if (step_q == STEP_W'(tlay_pkg::DIM_W - 1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== rtl/tlay_fifo.sv =====
// ----------------------------------------------------------------------------
// tlay_fifo
// Short job queue between the request front end and the rectangle generator.
// ----------------------------------------------------------------------------
module tlay_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tlay_pkg::job_t push_data,
	output logic           full,
	input  logic           pop,
	output tlay_pkg::job_t pop_data,
	output logic           empty
);

	localparam int PTR_W = $clog2(tlay_pkg::QUEUE_DEPTH);
	localparam int CNT_Q = $clog2(tlay_pkg::QUEUE_DEPTH + 1);

	tlay_pkg::job_t   mem_q [tlay_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_Q-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full     = cnt_q == CNT_Q'(tlay_pkg::QUEUE_DEPTH);
	assign empty    = cnt_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= (wr_q == PTR_W'(tlay_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (do_pop)
				rd_q <= (rd_q == PTR_W'(tlay_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_data;
	end

endmodule

// ===== rtl/tlay_front.sv =====
// ----------------------------------------------------------------------------
// tlay_front
// Takes a layout request, derives column sizes and divides extents by counts.
// ----------------------------------------------------------------------------
module tlay_front (
	input  logic               clk,
	input  logic               arst_n,
	input  tlay_pkg::cfg_t     cfg,
	input  logic               start,
	input  tlay_pkg::request_t request,
	output logic               busy,
	output logic               push,
	output tlay_pkg::job_t     push_data,
	input  logic               full
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_SCALE,
		F_DIV_STACK,
		F_DIV_MAIN,
		F_PUSH
	} fstate_t;

	fstate_t                          state_q;
	logic [tlay_pkg::CNT_W-1:0]       n_q;
	logic [tlay_pkg::CNT_W-1:0]       mc_q;
	logic [tlay_pkg::DIM_W-1:0]       ua_q;
	logic [tlay_pkg::DIM_W-1:0]       ub_q;
	logic [tlay_pkg::DIM_W-1:0]       mw_q;
	logic [tlay_pkg::DIM_W-1:0]       mh_q;
	logic [tlay_pkg::IDX_W-1:0]       mr_q;
	logic [tlay_pkg::DIM_W-1:0]       sh_q;
	logic [tlay_pkg::IDX_W-1:0]       sr_q;
	logic [tlay_pkg::TAG_W-1:0]       tag_q;

	logic [tlay_pkg::CNT_W-1:0]       n_in;
	logic [tlay_pkg::CNT_W-1:0]       mc_in;
	logic [tlay_pkg::CNT_W-1:0]       sc;
	logic [tlay_pkg::DIM_W-1:0]       ext_a;
	logic [tlay_pkg::DIM_W-1:0]       ext_b;
	logic [tlay_pkg::PAD_W:0]         op2;
	logic [tlay_pkg::DIM_W-1:0]       ua_in;
	logic [tlay_pkg::DIM_W-1:0]       ub_in;
	logic [2*tlay_pkg::DIM_W-1:0]     prod;
	tlay_pkg::div_req_t               div_req;
	tlay_pkg::div_rsp_t               div_rsp;

	tlay_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		if (request.num_views > tlay_pkg::CNT_W'(tlay_pkg::MAX_VIEWS))
			n_in = tlay_pkg::CNT_W'(tlay_pkg::MAX_VIEWS);
		else
			n_in = request.num_views;
		if (cfg.main_slots == '0)
			mc_in = tlay_pkg::CNT_W'(1);
		else if (cfg.main_slots > n_in)
			mc_in = n_in;
		else
			mc_in = cfg.main_slots;
		if (tlay_pkg::is_transposed(cfg.rotation)) begin
			ext_a = request.area_height;
			ext_b = request.area_width;
		end else begin
			ext_a = request.area_width;
			ext_b = request.area_height;
		end
		op2   = {cfg.edge_gap, 1'b0};
		ua_in = (ext_a >= tlay_pkg::DIM_W'(op2)) ? ext_a - tlay_pkg::DIM_W'(op2) : '0;
		ub_in = (ext_b >= tlay_pkg::DIM_W'(op2)) ? ext_b - tlay_pkg::DIM_W'(op2) : '0;
	end

	assign sc   = n_q - mc_q;
	assign prod = (2*tlay_pkg::DIM_W)'(ua_q) * (2*tlay_pkg::DIM_W)'(cfg.main_ratio);
	assign busy = state_q != F_IDLE;
	assign push = (state_q == F_PUSH) && !full;

	always_comb begin
		div_req.go  = 1'b0;
		div_req.num = ub_q;
		div_req.den = mc_q;
		case (state_q)
			F_SCALE: begin
				div_req.go  = 1'b1;
				div_req.den = (sc != '0) ? sc : mc_q;
			end
			F_DIV_STACK: begin
				div_req.go = div_rsp.done;
			end
			default: begin
				div_req.go = 1'b0;
			end
		endcase
	end

	always_comb begin
		push_data.n   = n_q;
		push_data.mc  = mc_q;
		push_data.ua  = ua_q;
		push_data.mw  = mw_q;
		push_data.sw  = ua_q - mw_q;
		push_data.mh  = mh_q;
		push_data.mr  = mr_q;
		push_data.sh  = sh_q;
		push_data.sr  = sr_q;
		push_data.tag = tag_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			n_q     <= '0;
			mc_q    <= '0;
			ua_q    <= '0;
			ub_q    <= '0;
			mw_q    <= '0;
			mh_q    <= '0;
			mr_q    <= '0;
			sh_q    <= '0;
			sr_q    <= '0;
			tag_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						n_q   <= n_in;
						mc_q  <= mc_in;
						ua_q  <= ua_in;
						ub_q  <= ub_in;
						tag_q <= request.request_tag;
						if (n_in != '0)
							state_q <= F_SCALE;
					end
				end
				F_SCALE: begin
					sh_q <= '0;
					sr_q <= '0;
					if (sc != '0) begin
						mw_q    <= prod[2*tlay_pkg::DIM_W-1:tlay_pkg::DIM_W];
						state_q <= F_DIV_STACK;
					end else begin
						mw_q    <= ua_q;
						state_q <= F_DIV_MAIN;
					end
				end
				F_DIV_STACK: begin
					if (div_rsp.done) begin
						sh_q    <= div_rsp.quo;
						sr_q    <= div_rsp.rem[tlay_pkg::IDX_W-1:0];
						state_q <= F_DIV_MAIN;
					end
				end
				F_DIV_MAIN: begin
					if (div_rsp.done) begin
						mh_q    <= div_rsp.quo;
						mr_q    <= div_rsp.rem[tlay_pkg::IDX_W-1:0];
						state_q <= F_PUSH;
					end
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/tlay_back.sv =====
// ----------------------------------------------------------------------------
// tlay_back
// Walks the views of one queued job and emits one rectangle beat per cycle.
// ----------------------------------------------------------------------------
module tlay_back (
	input  logic              clk,
	input  logic              arst_n,
	input  tlay_pkg::cfg_t    cfg,
	input  logic              empty,
	input  tlay_pkg::job_t    pop_data,
	output logic              pop,
	output logic              valid,
	output tlay_pkg::result_t result
);

	localparam int HW = tlay_pkg::DIM_W + 1;
	localparam int YW = tlay_pkg::DIM_W + 2;
	localparam int SW = tlay_pkg::POS_W;

	logic                       act_q;
	tlay_pkg::job_t             job_q;
	logic [tlay_pkg::IDX_W-1:0] i_q;
	logic [HW-1:0]              y_q;

	logic                       v_s1;
	logic [tlay_pkg::IDX_W-1:0] idx_s1;
	logic                       last_s1;
	logic [tlay_pkg::TAG_W-1:0] tag_s1;
	logic [tlay_pkg::DIM_W-1:0] ua_s1;
	logic [HW-1:0]              x_s1;
	logic [YW-1:0]              y_s1;
	logic [tlay_pkg::DIM_W-1:0] w_s1;
	logic [tlay_pkg::DIM_W-1:0] h_s1;

	logic                       in_main;
	logic                       main_first;
	logic                       stack_first;
	logic                       is_last;
	logic [HW-1:0]              ybase;
	logic [HW-1:0]              hraw;
	logic [tlay_pkg::DIM_W-1:0] wraw;
	logic [tlay_pkg::DIM_W-1:0] xraw;
	logic [tlay_pkg::PAD_W:0]   vp2;

	logic signed [SW-1:0]       xs;
	logic signed [SW-1:0]       ys;
	logic signed [SW-1:0]       ops;
	logic signed [SW-1:0]       px;
	logic signed [SW-1:0]       py;
	logic                       tr;

	assign pop         = !act_q && !empty;
	assign in_main     = {1'b0, i_q} < job_q.mc;
	assign main_first  = i_q == '0;
	assign stack_first = {1'b0, i_q} == job_q.mc;
	assign is_last     = {1'b0, i_q} == job_q.n - 1'b1;
	assign vp2         = {cfg.inner_gap, 1'b0};

	always_comb begin
		ybase = (main_first || stack_first) ? '0 : y_q;
		if (in_main) begin
			hraw = {1'b0, job_q.mh} + (main_first ? HW'(job_q.mr) : '0);
			wraw = job_q.mw;
			xraw = '0;
		end else begin
			hraw = {1'b0, job_q.sh} + (stack_first ? HW'(job_q.sr) : '0);
			wraw = job_q.sw;
			xraw = job_q.mw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= 1'b0;
			i_q   <= '0;
			y_q   <= '0;
			job_q <= '0;
			v_s1  <= 1'b0;
			valid <= 1'b0;
		end else begin
			v_s1  <= 1'b0;
			valid <= v_s1;
			if (pop) begin
				job_q <= pop_data;
				act_q <= 1'b1;
				i_q   <= '0;
			end else if (act_q) begin
				v_s1 <= 1'b1;
				i_q  <= i_q + 1'b1;
				y_q  <= ybase + hraw;
				if (is_last)
					act_q <= 1'b0;
			end
		end
	end

	// geometry stage
	always_ff @(posedge clk) begin
		if (act_q) begin
			idx_s1  <= i_q;
			last_s1 <= is_last;
			tag_s1  <= job_q.tag;
			ua_s1   <= job_q.ua;
			x_s1    <= HW'(xraw) + HW'(cfg.inner_gap);
			y_s1    <= YW'(ybase) + YW'(cfg.inner_gap);
			w_s1    <= (wraw >= tlay_pkg::DIM_W'(vp2)) ? wraw - tlay_pkg::DIM_W'(vp2) : '0;
			h_s1    <= (hraw >= HW'(vp2)) ? tlay_pkg::DIM_W'(hraw - HW'(vp2)) : '0;
		end
	end

	// mirror, transpose and clamp
	always_comb begin
		tr  = tlay_pkg::is_transposed(cfg.rotation);
		ops = $signed(SW'(cfg.edge_gap));
		if (tlay_pkg::is_mirrored(cfg.rotation))
			xs = $signed(SW'(ua_s1)) - $signed(SW'(w_s1)) - $signed(SW'(x_s1));
		else
			xs = $signed(SW'(x_s1));
		ys = $signed(SW'(y_s1));
		px = tr ? ys + ops : xs + ops;
		py = tr ? xs + ops : ys + ops;
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			result.view_index  <= idx_s1;
			result.rect_x      <= tlay_pkg::clamp16(px);
			result.rect_y      <= tlay_pkg::clamp16(py);
			result.rect_width  <= tr ? h_s1 : w_s1;
			result.rect_height <= tr ? w_s1 : h_s1;
			result.echo_tag    <= tag_s1;
			result.last_rect   <= last_s1;
		end
	end

endmodule

// ===== rtl/tall_tile_layout.sv =====
// ----------------------------------------------------------------------------
// tall_tile_layout
// Main and stack column tiling: one request in, one beat per view (up to 32).
// ----------------------------------------------------------------------------
// start to first rectangle: mostly set by the bit-serial divider, with two
//   divisions per request, or one when all views sit in the main column
// requests: a new one is taken only while busy is low, after the last job is
//   queued; busy stays high while that job waits for room in the job queue;
//   a job's rectangles leave one per cycle; the receiver cannot stall
// reset: all control clears; registers return to one main view, ratio 39322
module tall_tile_layout (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  tlay_pkg::request_t                   request,
	output logic                                 valid,
	output tlay_pkg::result_t                    result,
	input  logic                                 cfg_we,
	input  logic [tlay_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tlay_pkg::CFG_W-1:0]           cfg_data
);

	tlay_pkg::cfg_t cfg_q;
	tlay_pkg::job_t q_in;
	tlay_pkg::job_t q_out;
	logic           q_push;
	logic           q_full;
	logic           q_pop;
	logic           q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.main_slots <= tlay_pkg::RST_MAIN_COUNT;
			cfg_q.main_ratio <= tlay_pkg::RST_MAIN_RATIO;
			cfg_q.inner_gap  <= '0;
			cfg_q.edge_gap   <= '0;
			cfg_q.rotation   <= tlay_pkg::ROT_LEFT;
		end else if (cfg_we) begin
			case (cfg_index)
				tlay_pkg::CFG_MAIN_COUNT:
					cfg_q.main_slots <= cfg_data[tlay_pkg::CNT_W-1:0];
				tlay_pkg::CFG_MAIN_RATIO:
					cfg_q.main_ratio <= cfg_data[tlay_pkg::RATIO_W-1:0];
				tlay_pkg::CFG_VIEW_PADDING:
					cfg_q.inner_gap <= cfg_data[tlay_pkg::PAD_W-1:0];
				tlay_pkg::CFG_OUTER_PADDING:
					cfg_q.edge_gap <= cfg_data[tlay_pkg::PAD_W-1:0];
				tlay_pkg::CFG_ROTATION:
					cfg_q.rotation <= cfg_data[tlay_pkg::ROT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	tlay_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.start     (start),
		.request   (request),
		.busy      (busy),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full)
	);

	tlay_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_in),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (q_out),
		.empty     (q_empty)
	);

	tlay_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.empty    (q_empty),
		.pop_data (q_out),
		.pop      (q_pop),
		.valid    (valid),
		.result   (result)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full))
		else $error("job queue written while full");

	a_beats_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.last_rect |=> valid)
		else $error("gap inside a rectangle burst");

	a_index_steps: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !result.last_rect |=>
			result.view_index == $past(result.view_index) + 1'b1)
		else $error("view index did not advance by one");

	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && request.num_views != '0 |=> busy)
		else $error("nonempty request did not raise busy");

endmodule
